@@ src/ps2m_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2m_pkg
// shared types, constants and the init sequence table for the mouse host
// ----------------------------------------------------------------------------
package ps2m_pkg;

   localparam int INIT_LEN_DEF  = 16;
   localparam int ACC_WIDTH_DEF = 16;
   localparam int SEQ_DEPTH     = 32;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [7:0]  GAP_RESET      = 8'd20;
   localparam logic [11:0] INIT_TO_RESET  = 12'd3500;
   localparam logic [11:0] PKT_TO_RESET   = 12'd100;
   localparam logic [11:0] TICK_MAX       = 12'hfff;

   typedef enum logic [1:0] {
      CMD_BYTE    = 2'd0,
      CMD_TICK    = 2'd1,
      CMD_READ    = 2'd2,
      CMD_RESTART = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_GAP      = 2'd0,
      REG_INIT_TO  = 2'd1,
      REG_PKT_TO   = 2'd2,
      REG_NONE     = 2'd3
   } reg_type;

   typedef struct packed {
      cmd_type    command;
      logic [7:0] rx_byte;
   } word_type;

   typedef struct packed {
      logic [7:0]  gap;
      logic [11:0] init_to;
      logic [11:0] pkt_to;
   } cfg_type;

   function automatic logic [7:0] seq_rom(input logic [4:0] i);
      logic [7:0] r;
      case (i[3:0])
         4'd0:  r = 8'h01;
         4'd1:  r = 8'hff;
         4'd2:  r = 8'h82;
         4'd3:  r = 8'h08;
         4'd4:  r = 8'hf3;
         4'd5:  r = 8'd200;
         4'd6:  r = 8'hf3;
         4'd7:  r = 8'd100;
         4'd8:  r = 8'hf3;
         4'd9:  r = 8'd80;
         4'd10: r = 8'hf2;
         4'd11: r = 8'h01;
         4'd12: r = 8'h81;
         4'd13: r = 8'h01;
         4'd14: r = 8'hf4;
         default: r = 8'h00;
      endcase
      if (i[4]) r = 8'h00;
      return r;
   endfunction

endpackage
`default_nettype wire

@@ src/ps2_wheel_mouse_host_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2_wheel_mouse_host_core
// ps/2 wheel mouse host: init sequencing and packet decoding per event word
// ----------------------------------------------------------------------------
// One word a clock is taken while the output queue has room, giving one
// result word; a four-word input queue feeds the decoder and a two-entry
// output queue keeps input flowing while a result waits. Results are
// registered into the output queue.
module ps2_wheel_mouse_host_core
   import ps2m_pkg::*;
#(
   parameter int INIT_LEN  = INIT_LEN_DEF,
   parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic             rsp_tx_valid,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_is_active,
   output logic             rsp_wheel_mode,
   output logic [2:0]       rsp_button_bits,
   output logic signed [15:0] rsp_delta_x,
   output logic signed [15:0] rsp_delta_y,
   output logic signed [15:0] rsp_delta_z,
   output logic             rsp_changed,
   output logic             rsp_size_toggled,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   cfg_type  cfg_ff, cfg_in;
   logic     q_valid, q_take;
   word_type q_word;
   reg_type  sel;

   assign pready = 1'b1;
   always_comb begin
      case (paddr)
         4'd0:    sel = REG_GAP;
         4'd4:    sel = REG_INIT_TO;
         4'd8:    sel = REG_PKT_TO;
         default: sel = REG_NONE;
      endcase
      cfg_in = cfg_ff;
      prdata = '0;
      case (sel)
         REG_GAP:     prdata = 32'(cfg_ff.gap);
         REG_INIT_TO: prdata = 32'(cfg_ff.init_to);
         REG_PKT_TO:  prdata = 32'(cfg_ff.pkt_to);
         default:     prdata = '0;
      endcase
      if (psel && penable && pwrite) begin
         case (sel)
            REG_GAP:     cfg_in.gap = pwdata[7:0];
            REG_INIT_TO: cfg_in.init_to = pwdata[11:0];
            REG_PKT_TO:  cfg_in.pkt_to = pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{gap: GAP_RESET, init_to: INIT_TO_RESET, pkt_to: PKT_TO_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ps2m_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock, .reset, .req_push, .req_full, .req_command, .req_rx_byte,
      .q_valid, .q_take, .q_word
   );

   ps2m_back #(.INIT_LEN(INIT_LEN), .ACC_WIDTH(ACC_WIDTH)) u_back (
      .clock, .reset, .cfg(cfg_ff), .q_valid, .q_take, .q_word,
      .rsp_empty, .rsp_pop, .rsp_tx_valid, .rsp_tx_byte, .rsp_is_active,
      .rsp_wheel_mode, .rsp_button_bits, .rsp_delta_x, .rsp_delta_y,
      .rsp_delta_z, .rsp_changed, .rsp_size_toggled
   );

   // a sent byte only happens while init is still running
   a_tx_inactive: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_tx_valid) |-> !rsp_is_active)
      else $error("tx while active");
   // the decoder never takes a word the front has not offered
   a_take: assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_valid)
      else $error("take without word");
   // the tx byte is zero whenever no byte is sent
   a_txb: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_tx_valid) |-> (rsp_tx_byte == 8'h00))
      else $error("stray tx byte");
endmodule
`default_nettype wire

@@ src/ps2m_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2m_front
// accepts input words, maps the command code and stores them in the word queue
// ----------------------------------------------------------------------------
module ps2m_front
   import ps2m_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_push,
   output logic          req_full,
   input  wire logic [1:0] req_command,
   input  wire logic [7:0] req_rx_byte,
   output logic          q_valid,
   input  wire logic     q_take,
   output word_type      q_word
);
   localparam int AW = $clog2(DEPTH);

   word_type          mem_ff [DEPTH];
   logic [AW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]       cnt_ff, cnt_in;
   logic              do_push, do_pop;
   word_type          w;

   always_comb begin
      case (req_command)
         2'd0:    w.command = CMD_BYTE;
         2'd1:    w.command = CMD_TICK;
         2'd2:    w.command = CMD_READ;
         default: w.command = CMD_RESTART;
      endcase
      w.rx_byte = req_rx_byte;
   end

   assign req_full = (cnt_ff == (AW+1)'(DEPTH));
   assign do_push  = req_push && !req_full;
   assign q_valid  = (cnt_ff != '0);
   assign do_pop   = q_take && q_valid;
   assign q_word   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) mem_ff[wr_ff] <= w;
   end
endmodule
`default_nettype wire

@@ src/ps2m_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2m_back
// init sequencer, packet decoder and accumulators with a two-entry result skid
// ----------------------------------------------------------------------------
module ps2m_back
   import ps2m_pkg::*;
#(
   parameter int INIT_LEN  = INIT_LEN_DEF,
   parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  cfg_type          cfg,
   input  wire logic        q_valid,
   output logic             q_take,
   input  word_type         q_word,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic             rsp_tx_valid,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_is_active,
   output logic             rsp_wheel_mode,
   output logic [2:0]       rsp_button_bits,
   output logic signed [15:0] rsp_delta_x,
   output logic signed [15:0] rsp_delta_y,
   output logic signed [15:0] rsp_delta_z,
   output logic             rsp_changed,
   output logic             rsp_size_toggled
);
   localparam int RW = 1 + 8 + 1 + 1 + 3 + 16 + 16 + 16 + 1 + 1;
   localparam logic signed [ACC_WIDTH+1:0] LIM_HI =
      (ACC_WIDTH+2)'((64'sd1 <<< (ACC_WIDTH-1)) - 64'sd1);
   localparam logic signed [ACC_WIDTH+1:0] LIM_LO = -LIM_HI - (ACC_WIDTH+2)'(1);

   logic [4:0]  seq_ff, seq_in;
   logic [6:0]  send_ff, send_in, recv_ff, recv_in;
   logic [7:0]  last_ff, last_in, gap_ff, gap_in;
   logic        run_ff, run_in, four_ff, four_in, evt_ff, evt_in;
   logic [11:0] tick_ff, tick_in;
   logic [1:0]  fill_ff, fill_in;
   logic [7:0]  pb_ff [3];
   logic [7:0]  pb_in [3];
   logic signed [ACC_WIDTH-1:0] ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic [2:0]  btn_ff, btn_in;

   logic [RW-1:0] res, sk_ff [2];
   logic [RW-1:0] sk0_in, sk1_in;
   logic [1:0]    sk_cnt_ff;
   logic          go;
   logic          popd;

   function automatic logic [7:0] rom_at(input logic [4:0] i);
      return (32'(i) >= INIT_LEN) ? 8'h00 : seq_rom(i);
   endfunction

   function automatic logic signed [ACC_WIDTH-1:0] sat_add(
      input logic signed [ACC_WIDTH-1:0] a, input logic signed [9:0] d);
      logic signed [ACC_WIDTH+1:0] v;
      v = (ACC_WIDTH+2)'(a) + (ACC_WIDTH+2)'(d);
      if (v > LIM_HI) v = LIM_HI;
      if (v < LIM_LO) v = LIM_LO;
      return v[ACC_WIDTH-1:0];
   endfunction

   assign q_take = q_valid && (sk_cnt_ff != 2'd2);
   assign go     = q_take;

   always_comb begin
      logic       txv, tog, chg;
      logic [7:0] txb, e, b0, b1, b2, b;
      logic [2:0] size;
      logic signed [9:0] dx, dy, dz;
      logic signed [15:0] ox, oy, oz;
      seq_in = seq_ff; send_in = send_ff; recv_in = recv_ff; last_in = last_ff;
      gap_in = gap_ff; run_in = run_ff; four_in = four_ff; evt_in = evt_ff;
      tick_in = tick_ff; fill_in = fill_ff; pb_in = pb_ff;
      ax_in = ax_ff; ay_in = ay_ff; az_in = az_ff; btn_in = btn_ff;
      txv = 1'b0; txb = 8'h00; tog = 1'b0;
      ox = '0; oy = '0; oz = '0;
      b = q_word.rx_byte;
      size = four_ff ? 3'd4 : 3'd3;
      e = 8'h00; b0 = 8'h00; b1 = 8'h00; b2 = 8'h00; dx = '0; dy = '0; dz = '0;
      case (q_word.command)
         CMD_BYTE: begin
            if (run_ff) begin
               if (fill_ff == 2'd0) tick_in = '0;
               if ((3'(fill_ff) + 3'd1 < size) && fill_ff < 2'd3) begin
                  pb_in[fill_ff] = b;
                  fill_in = fill_ff + 2'd1;
               end else begin
                  b0 = pb_ff[0]; b1 = pb_ff[1];
                  b2 = (size == 3'd3) ? b : pb_ff[2];
                  btn_in = b0[2:0];
                  dx = $signed({b0[4], b0[4], b1});
                  dy = $signed({b0[5], b0[5], b2});
                  ax_in = sat_add(ax_ff, dx);
                  ay_in = sat_add(ay_ff, -dy);
                  if (size == 3'd4) begin
                     dz = $signed({{6{b[3]}}, b[3:0]});
                     az_in = sat_add(az_ff, dz);
                  end
                  evt_in = 1'b1;
                  fill_in = '0;
                  tick_in = '0;
               end
            end else if (seq_ff != '0 && recv_ff != '0) begin
               last_in = b;
               recv_in = recv_ff - 7'd1;
            end
         end
         CMD_TICK: begin
            if (run_ff) begin
               if (fill_ff != '0) begin
                  if (tick_ff != TICK_MAX) tick_in = tick_ff + 12'd1;
                  if (tick_in >= cfg.pkt_to) begin
                     four_in = !four_ff;
                     fill_in = '0;
                     tick_in = '0;
                     tog = 1'b1;
                  end
               end
            end else begin
               if (recv_ff != '0 && tick_ff != TICK_MAX) tick_in = tick_ff + 12'd1;
               if (gap_ff == '0) begin
                  gap_in = (cfg.gap != '0) ? cfg.gap - 8'd1 : 8'd0;
                  if (seq_ff == '0) begin
                     e = rom_at(5'd0);
                     send_in = e[6:0];
                     recv_in = '0;
                     seq_in = 5'd1;
                     fill_in = '0;
                     tick_in = '0;
                     if (send_in == '0) run_in = 1'b1;
                  end else if (recv_ff != '0) begin
                     if (tick_in >= cfg.init_to) begin
                        seq_in = '0; recv_in = '0; send_in = '0;
                     end
                  end else if (send_ff != '0) begin
                     txv = 1'b1;
                     txb = rom_at(seq_ff);
                     seq_in = seq_ff + 5'd1;
                     send_in = send_ff - 7'd1;
                     recv_in = 7'd1;
                     tick_in = '0;
                  end else begin
                     e = rom_at(seq_ff);
                     seq_in = seq_ff + 5'd1;
                     if (e[7]) begin
                        recv_in = e[6:0];
                        four_in = (last_ff == 8'd3);
                     end else begin
                        send_in = e[6:0];
                     end
                     if (recv_in == '0 && send_in == '0) run_in = 1'b1;
                  end
               end else begin
                  gap_in = gap_ff - 8'd1;
               end
            end
         end
         CMD_RESTART: begin
            seq_in = '0; send_in = '0; recv_in = '0; run_in = 1'b0;
            fill_in = '0; gap_in = '0; tick_in = '0;
         end
         default: ;
      endcase
      // flag as it stands after this word, before a read clears it
      chg = evt_in;
      if (q_word.command == CMD_READ) begin
         ox = 16'(ax_ff); oy = 16'(ay_ff); oz = 16'(az_ff);
         ax_in = '0; ay_in = '0; az_in = '0; evt_in = 1'b0;
      end
      res = {txv, txb, run_in, four_in, btn_in, ox, oy, oz, chg, tog};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= '0; send_ff <= '0; recv_ff <= '0; last_ff <= '0; gap_ff <= '0;
         run_ff <= 1'b0; four_ff <= 1'b0; evt_ff <= 1'b0; tick_ff <= '0;
         fill_ff <= '0; ax_ff <= '0; ay_ff <= '0; az_ff <= '0; btn_ff <= '0;
         pb_ff[0] <= '0; pb_ff[1] <= '0; pb_ff[2] <= '0;
      end else if (go) begin
         seq_ff <= seq_in; send_ff <= send_in; recv_ff <= recv_in;
         last_ff <= last_in; gap_ff <= gap_in; run_ff <= run_in;
         four_ff <= four_in; evt_ff <= evt_in; tick_ff <= tick_in;
         fill_ff <= fill_in; ax_ff <= ax_in; ay_ff <= ay_in; az_ff <= az_in;
         btn_ff <= btn_in; pb_ff <= pb_in;
      end
   end

   // two-entry output queue, slot 0 is the oldest word
   assign popd = rsp_pop && !rsp_empty;

   always_comb begin
      sk0_in = sk_ff[0];
      sk1_in = sk_ff[1];
      if (popd) sk0_in = sk_ff[1];
      if (go) begin
         if (sk_cnt_ff == 2'd0 || (sk_cnt_ff == 2'd1 && popd)) sk0_in = res;
         else sk1_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sk_cnt_ff <= '0;
      end else begin
         sk_cnt_ff <= sk_cnt_ff + 2'(go) - 2'(popd);
      end
      sk_ff[0] <= sk0_in;
      sk_ff[1] <= sk1_in;
   end

   assign rsp_empty = (sk_cnt_ff == '0);
   assign {rsp_tx_valid, rsp_tx_byte, rsp_is_active, rsp_wheel_mode, rsp_button_bits,
           rsp_delta_x, rsp_delta_y, rsp_delta_z, rsp_changed, rsp_size_toggled} = sk_ff[0];
endmodule
`default_nettype wire
